FILE: hw/rtl/fcce_pkg.sv
// fcce_pkg: shared constants and types for the fat cluster chain engine
// used by fcce_byte_ram and fat_cluster_chain_engine
package fcce_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_FREE   = 3'd3;
  localparam logic [2:0] KIND_SEEK   = 3'd4;
  localparam logic [2:0] KIND_EXTEND = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADSTART = 2'd2;
  localparam logic [1:0] ST_ENDED   = 2'd3;

  localparam logic [1:0] REG_FAT12 = 2'd0;
  localparam logic [1:0] REG_BOUND = 2'd1;
  localparam logic [1:0] REG_HINT  = 2'd2;
  localparam logic [1:0] REG_SHIFT = 2'd3;

  localparam logic [15:0] MASK12   = 16'h0fff;
  localparam logic [15:0] MASK16   = 16'hffff;
  localparam logic [15:0] HI_NIB   = 16'hf000;
  localparam logic [15:0] LO_NIB   = 16'h000f;
  localparam logic [16:0] LINK_LIMIT = 17'h10000;

endpackage

FILE: hw/rtl/fcce_byte_ram.sv
// fcce_byte_ram: single port byte store of the allocation table
// one access per cycle, registered read data; depends on fcce_pkg
module fcce_byte_ram (
  input  logic          clk,
  input  logic          we,
  input  fcce_pkg::addr_t addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  import fcce_pkg::*;

  logic [7:0] mem [TABLE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/fat_cluster_chain_engine.sv
// fat_cluster_chain_engine: fat12/fat16 table engine, sequencer over fcce_byte_ram
// depends on fcce_pkg and fcce_byte_ram
// busy: each read, write, or entry of a scan or chain walk takes S_CHECK, S_F0 to S_F2,
// S_EVAL, plus S_W0 and S_W1 when rewritten, only S_CHECK when outside the store, then
// S_DONE; strobe in the cycle after; one word at a time; the strobe lasts one cycle and
// the receiver cannot stall; reset: synchronous, then a clearing pass with busy high
module fat_cluster_chain_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_cluster,
  input  logic [15:0] in_link_value,
  input  logic [31:0] in_file_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_cluster,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import fcce_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_F0    = 10'b0000001000,
    S_F1    = 10'b0000010000,
    S_F2    = 10'b0000100000,
    S_EVAL  = 10'b0001000000,
    S_W0    = 10'b0010000000,
    S_W1    = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    P_READ, P_WRITE, P_FREE, P_SEEK, P_WALK, P_SCAN, P_LINK, P_MARK
  } step_t;

  state_t      state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        fat12_r, fat12_nxt;
  logic [15:0] bound_r, bound_nxt;
  logic [15:0] hint_r, hint_nxt;
  logic [4:0]  shift_r, shift_nxt;
  logic        ext_r, ext_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] link_r, link_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [15:0] fnd_r, fnd_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [31:0] target_r, target_nxt;
  logic [15:0] sc_start_r, sc_start_nxt;
  logic [15:0] sc_i_r, sc_i_nxt;
  logic [15:0] sc_n_r, sc_n_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] ent_r, ent_nxt;
  logic [15:0] wword_r, wword_nxt;
  logic [15:0] put_v;
  logic [15:0] put_m;
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [15:0] oc_r, oc_nxt;
  addr_t       clr_r, clr_nxt;

  logic        ram_we;
  addr_t       ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  logic [15:0] mask_w, end_w;
  logic [17:0] off3_w;
  logic [16:0] off_w;
  logic        ok_w;
  addr_t       a0_w, a1_w;
  logic [15:0] fword_w, fent_w;
  logic [15:0] scan_src, sc_start_w, sc_first_w, acc_adv_w;
  logic [16:0] sc_inc_w, adv_inc_w;

  fcce_byte_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign mask_w = fat12_r ? MASK12 : MASK16;
  assign end_w  = mask_w & ~16'h0007;
  assign off3_w = {1'b0, acc_r, 1'b0} + {2'b00, acc_r};
  assign off_w  = fat12_r ? off3_w[17:1] : {acc_r, 1'b0};
  assign ok_w   = off_w < 17'(TABLE_BYTES - 1);
  assign a0_w   = off_w[ADDR_W-1:0];
  assign a1_w   = a0_w + addr_t'(1);

  assign fword_w = {ram_rdata, lo_r};
  assign fent_w  = fat12_r ? (acc_r[0] ? {4'h0, fword_w[15:4]} : (fword_w & MASK12))
                           : fword_w;

  assign put_m = put_v & mask_w;

  assign scan_src   = (state_r == S_IDLE) ? in_cluster : acc_r;
  assign sc_start_w = (scan_src == 16'd0) ? hint_r : scan_src;
  assign sc_inc_w   = {1'b0, sc_start_w} + 17'd1;
  assign sc_first_w = (sc_inc_w >= {1'b0, bound_r}) ? 16'd2 : sc_inc_w[15:0];
  assign adv_inc_w  = {1'b0, acc_r} + 17'd1;
  assign acc_adv_w  = (adv_inc_w >= {1'b0, bound_r}) ? 16'd2 : adv_inc_w[15:0];

  assign busy = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_result_cluster = oc_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = a0_w;
    ram_wdata = wword_r[7:0];
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = 8'h00;
      end
      S_F1: ram_addr = a1_w;
      S_W0: ram_we = 1'b1;
      S_W1: begin
        ram_we    = 1'b1;
        ram_addr  = a1_w;
        ram_wdata = wword_r[15:8];
      end
      default: ram_addr = a0_w;
    endcase
  end

  always_comb begin
    state_nxt = state_r; step_nxt = step_r;
    fat12_nxt = fat12_r; bound_nxt = bound_r; hint_nxt = hint_r; shift_nxt = shift_r;
    ext_nxt = ext_r; acc_nxt = acc_r; link_nxt = link_r; tail_nxt = tail_r;
    fnd_nxt = fnd_r; cnt_nxt = cnt_r; target_nxt = target_r;
    sc_start_nxt = sc_start_r; sc_i_nxt = sc_i_r; sc_n_nxt = sc_n_r;
    lo_nxt = lo_r; word_nxt = word_r; ent_nxt = ent_r; wword_nxt = wword_r;
    ov_nxt = 1'b0; os_nxt = os_r; oc_nxt = oc_r; clr_nxt = clr_r;
    put_v = 16'd0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FAT12: fat12_nxt = cfg_wdata[0];
        REG_BOUND: bound_nxt = cfg_wdata;
        REG_HINT:  hint_nxt  = cfg_wdata;
        REG_SHIFT: shift_nxt = cfg_wdata[4:0];
        default:   fat12_nxt = fat12_r;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + addr_t'(1);
        if (clr_r == addr_t'(TABLE_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          acc_nxt  = in_cluster;
          link_nxt = in_link_value;
          cnt_nxt  = 17'd0;
          ext_nxt  = 1'b0;
          os_nxt   = ST_OK;
          oc_nxt   = 16'd0;
          state_nxt = S_CHECK;
          unique case (in_kind)
            KIND_READ:  step_nxt = P_READ;
            KIND_WRITE: step_nxt = P_WRITE;
            KIND_FIND: begin
              step_nxt = P_SCAN;
              sc_start_nxt = sc_start_w;
              acc_nxt  = sc_first_w;
              sc_i_nxt = 16'd0;
              sc_n_nxt = bound_r - 16'd2;
              if (bound_r <= 16'd2) begin
                os_nxt = ST_NOSPACE;
                state_nxt = S_DONE;
              end
            end
            KIND_FREE, KIND_EXTEND: begin
              step_nxt = (in_kind == KIND_FREE) ? P_FREE : P_WALK;
              if (in_cluster < 16'd2 || in_cluster >= end_w) begin
                os_nxt = ST_BADSTART;
                state_nxt = S_DONE;
              end
            end
            KIND_SEEK: begin
              step_nxt = P_SEEK;
              target_nxt = in_file_offset >> shift_r;
              if (in_cluster > bound_r) begin
                os_nxt = ST_ENDED;
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        state_nxt = S_F0;
        unique case (step_r)
          P_READ, P_WRITE: if (!ok_w) begin
            os_nxt = ST_ENDED; state_nxt = S_DONE;
          end
          P_FREE, P_WALK: if (cnt_r == LINK_LIMIT || !ok_w) begin
            os_nxt = ST_ENDED; state_nxt = S_DONE;
          end
          P_SEEK: begin
            if ({15'd0, cnt_r} >= target_r) begin
              oc_nxt = acc_r; state_nxt = S_DONE;
            end else if (cnt_r == LINK_LIMIT || !ok_w) begin
              os_nxt = ST_ENDED; state_nxt = S_DONE;
            end
          end
          P_SCAN: begin
            if (sc_i_r == sc_n_r || acc_r == sc_start_r) begin
              os_nxt = ST_NOSPACE; state_nxt = S_DONE;
            end else if (!ok_w) begin
              acc_nxt = acc_adv_w; sc_i_nxt = sc_i_r + 16'd1; state_nxt = S_CHECK;
            end
          end
          default: state_nxt = S_F0;
        endcase
      end
      S_F0: state_nxt = S_F1;
      S_F1: begin
        lo_nxt = ram_rdata;
        state_nxt = S_F2;
      end
      S_F2: begin
        word_nxt = fword_w;
        ent_nxt  = fent_w;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_W0;
        unique case (step_r)
          P_READ: begin
            oc_nxt = ent_r; state_nxt = S_DONE;
          end
          P_WRITE: put_v = link_r;
          P_FREE:  put_v = 16'd0;
          P_LINK:  put_v = fnd_r;
          P_MARK:  put_v = mask_w;
          P_SEEK: begin
            if (ent_r >= end_w || ent_r < 16'd2) begin
              os_nxt = ST_ENDED; state_nxt = S_DONE;
            end else begin
              acc_nxt = ent_r; cnt_nxt = cnt_r + 17'd1; state_nxt = S_CHECK;
            end
          end
          P_WALK: begin
            state_nxt = S_CHECK;
            if (ent_r >= end_w) begin
              tail_nxt = acc_r;
              ext_nxt  = 1'b1;
              step_nxt = P_SCAN;
              sc_start_nxt = sc_start_w;
              acc_nxt  = sc_first_w;
              sc_i_nxt = 16'd0;
              sc_n_nxt = bound_r - 16'd2;
              if (bound_r <= 16'd2) begin
                os_nxt = ST_NOSPACE; state_nxt = S_DONE;
              end
            end else if (ent_r < 16'd2) begin
              os_nxt = ST_ENDED; state_nxt = S_DONE;
            end else begin
              acc_nxt = ent_r; cnt_nxt = cnt_r + 17'd1;
            end
          end
          default: begin
            state_nxt = S_CHECK;
            if (ent_r == 16'd0) begin
              if (ext_r) begin
                fnd_nxt = acc_r; acc_nxt = tail_r; step_nxt = P_LINK;
              end else begin
                oc_nxt = acc_r; state_nxt = S_DONE;
              end
            end else begin
              acc_nxt = acc_adv_w; sc_i_nxt = sc_i_r + 16'd1;
            end
          end
        endcase
        if (fat12_r) begin
          if (acc_r[0]) wword_nxt = {put_m[11:0], word_r[3:0] & LO_NIB[3:0]};
          else wword_nxt = (word_r & HI_NIB) | (put_m & MASK12);
        end else begin
          wword_nxt = put_m;
        end
      end
      S_W0: state_nxt = S_W1;
      S_W1: begin
        state_nxt = S_DONE;
        unique case (step_r)
          P_FREE: begin
            if (ent_r >= end_w) begin
              state_nxt = S_DONE;
            end else if (ent_r < 16'd2) begin
              os_nxt = ST_ENDED;
            end else begin
              acc_nxt = ent_r; cnt_nxt = cnt_r + 17'd1; state_nxt = S_CHECK;
            end
          end
          P_LINK: begin
            acc_nxt = fnd_r; step_nxt = P_MARK; state_nxt = S_CHECK;
          end
          P_MARK: oc_nxt = fnd_r;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        if (os_r != ST_OK) oc_nxt = 16'd0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      fat12_r <= 1'b0;
      bound_r <= 16'd4095;
      hint_r  <= 16'd2;
      shift_r <= 5'd9;
      step_r  <= P_READ;
      ext_r   <= 1'b0;
      os_r    <= ST_OK;
      oc_r    <= 16'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      fat12_r <= fat12_nxt;
      bound_r <= bound_nxt;
      hint_r  <= hint_nxt;
      shift_r <= shift_nxt;
      step_r  <= step_nxt;
      ext_r   <= ext_nxt;
      os_r    <= os_nxt;
      oc_r    <= oc_nxt;
    end
    acc_r <= acc_nxt; link_r <= link_nxt; tail_r <= tail_nxt; fnd_r <= fnd_nxt;
    cnt_r <= cnt_nxt; target_r <= target_nxt;
    sc_start_r <= sc_start_nxt; sc_i_r <= sc_i_nxt; sc_n_r <= sc_n_nxt;
    lo_r <= lo_nxt; word_r <= word_nxt; ent_r <= ent_nxt; wword_r <= wword_nxt;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("strobe without work");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_result_cluster == 16'd0)
    else $error("nonzero result on error");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("word accepted but not busy");

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for fat_cluster_chain_engine
// holds its own model of the allocation table and checks each result word in order
// depends on fcce_pkg and the engine rtl
module testbench;
  import fcce_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
  } answer_t;

  class fat_table_model;
    logic [7:0]  tbl [TABLE_BYTES];
    bit          fat12;
    bit [15:0]   bound;
    bit [15:0]   hint;
    bit [4:0]    shift;
    answer_t     pending_q[$];
    int          errors;

    function new();
      foreach (tbl[i]) tbl[i] = 8'h00;
      fat12 = 0;
      bound = 16'd4095;
      hint = 16'd2;
      shift = 5'd9;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_FAT12: fat12 = v[0];
        REG_BOUND: bound = v;
        REG_HINT:  hint = v;
        REG_SHIFT: shift = v[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned mask();
      return fat12 ? 32'(MASK12) : 32'(MASK16);
    endfunction

    function int unsigned offs(int unsigned cl);
      return fat12 ? (cl * 3) >> 1 : cl * 2;
    endfunction

    function bit ok(int unsigned cl);
      return offs(cl) + 1 < TABLE_BYTES;
    endfunction

    function int unsigned get(int unsigned cl);
      int unsigned o;
      int unsigned w;
      o = offs(cl);
      w = {tbl[o+1], tbl[o]};
      if (fat12) return cl[0] ? (w >> 4) : (w & 32'(MASK12));
      return w;
    endfunction

    function void put(int unsigned cl, int unsigned v);
      int unsigned o;
      int unsigned w;
      o = offs(cl);
      w = {tbl[o+1], tbl[o]};
      v = v & mask();
      if (fat12) begin
        if (cl[0]) v = (v << 4) | (w & 32'(LO_NIB));
        else v = v | (w & 32'(HI_NIB));
      end
      tbl[o] = v[7:0];
      tbl[o+1] = v[15:8];
    endfunction

    function bit scan(int unsigned from, output int unsigned found, inout int unsigned steps);
      int unsigned c;
      found = 0;
      if (from == 0) from = hint;
      if (bound <= 2) return 0;
      c = from + 1;
      if (c >= bound) c = 2;
      for (int unsigned i = 0; i < bound - 2; i++) begin
        if (c == from) break;
        steps++;
        if (ok(c) && get(c) == 0) begin
          found = c;
          return 1;
        end
        c++;
        if (c >= bound) c = 2;
      end
      return 0;
    endfunction

    function answer_t run(logic [2:0] kind, logic [15:0] cl_in, logic [15:0] link,
                          logic [31:0] foff, output int unsigned steps);
      int unsigned   c;
      int unsigned   e;
      int unsigned   fnd;
      int unsigned   endv;
      longint unsigned target;
      answer_t       a;
      c = cl_in;
      endv = mask() & ~32'd7;
      steps = 1;
      a.status = ST_OK;
      a.cluster = 16'h0;
      case (kind)
        KIND_READ: begin
          if (ok(c)) a.cluster = 16'(get(c));
          else a.status = ST_ENDED;
        end
        KIND_WRITE: begin
          if (ok(c)) put(c, link);
          else a.status = ST_ENDED;
        end
        KIND_FIND: begin
          if (scan(c, fnd, steps)) a.cluster = 16'(fnd);
          else a.status = ST_NOSPACE;
        end
        KIND_FREE: begin
          if (c < 2 || c >= endv) a.status = ST_BADSTART;
          else begin
            for (int unsigned i = 0; ; i++) begin
              steps++;
              if (i >= LINK_LIMIT || !ok(c)) begin
                a.status = ST_ENDED;
                break;
              end
              e = get(c);
              put(c, 0);
              if (e >= endv) break;
              if (e < 2) begin
                a.status = ST_ENDED;
                break;
              end
              c = e;
            end
          end
        end
        KIND_SEEK: begin
          if (c > bound) a.status = ST_ENDED;
          else begin
            target = foff >> shift;
            for (longint unsigned k = 0; k < target; k++) begin
              steps++;
              if (k >= LINK_LIMIT || !ok(c)) begin
                a.status = ST_ENDED;
                break;
              end
              e = get(c);
              if (e >= endv || e < 2) begin
                a.status = ST_ENDED;
                break;
              end
              c = e;
            end
            if (a.status == ST_OK) a.cluster = 16'(c);
          end
        end
        KIND_EXTEND: begin
          if (c < 2 || c >= endv) a.status = ST_BADSTART;
          else begin
            for (int unsigned i = 0; ; i++) begin
              steps++;
              if (i >= LINK_LIMIT || !ok(c)) begin
                a.status = ST_ENDED;
                break;
              end
              e = get(c);
              if (e >= endv) break;
              if (e < 2) begin
                a.status = ST_ENDED;
                break;
              end
              c = e;
            end
            if (a.status == ST_OK) begin
              if (!scan(c, fnd, steps)) a.status = ST_NOSPACE;
              else begin
                put(c, fnd);
                put(fnd, mask());
                a.cluster = 16'(fnd);
              end
            end
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function int unsigned cost(logic [2:0] kind, logic [15:0] cl, logic [15:0] link,
                               logic [31:0] foff);
      logic [7:0]  saved [TABLE_BYTES];
      int unsigned steps;
      answer_t     a;
      saved = tbl;
      a = run(kind, cl, link, foff, steps);
      tbl = saved;
      return steps;
    endfunction

    function void note_input(logic [2:0] kind, logic [15:0] cl, logic [15:0] link,
                             logic [31:0] foff);
      int unsigned steps;
      pending_q.push_back(run(kind, cl, link, foff, steps));
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] res);
      answer_t a;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status %0d cluster %h", $time, st, res);
        return;
      end
      a = pending_q.pop_front();
      if (st !== a.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, a.status, st);
      end
      if (res !== a.cluster) begin
        errors++;
        $display("%0t: result_cluster expected %h actual %h", $time, a.cluster, res);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [15:0] in_cluster;
  logic [15:0] in_link_value;
  logic [31:0] in_file_offset;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_result_cluster;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  fat_table_model table_model;
  bit idle_on;

  fat_cluster_chain_engine u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_cluster(in_cluster), .in_link_value(in_link_value),
    .in_file_offset(in_file_offset), .out_valid(out_valid), .out_status(out_status),
    .out_result_cluster(out_result_cluster), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) table_model.write_reg(cfg_index, cfg_wdata);
      if (start && !busy)
        table_model.note_input(in_kind, in_cluster, in_link_value, in_file_offset);
      if (out_valid) table_model.check_result(out_status, out_result_cluster);
    end
  end

  task automatic send(input logic [2:0] k, input logic [15:0] c, input logic [15:0] l,
                      input logic [31:0] o);
    @(posedge clk);
    start <= 1'b1;
    in_kind <= k;
    in_cluster <= c;
    in_link_value <= l;
    in_file_offset <= o;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    if (idle_on && $urandom_range(99) < 16) repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    while (table_model.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    logic [2:0]  k;
    logic [15:0] c;
    logic [15:0] l;
    logic [31:0] o;
    int unsigned r;
    int unsigned span;
    do begin
      r = $urandom_range(99);
      k = r < 15 ? KIND_READ : r < 35 ? KIND_WRITE : r < 50 ? KIND_FIND :
          r < 62 ? KIND_FREE : r < 75 ? KIND_SEEK : r < 95 ? KIND_EXTEND :
          3'($urandom_range(6, 7));
      span = table_model.bound < 600 ? table_model.bound + 2 : 600;
      case ($urandom_range(9))
        0: c = 16'($urandom);
        1: c = 16'($urandom_range(0, 3));
        default: c = 16'($urandom_range(2, span));
      endcase
      case ($urandom_range(5))
        0: l = 16'(table_model.mask());
        1: l = 16'($urandom);
        2: l = 16'h0;
        default: l = 16'(c + $urandom_range(1, 6));
      endcase
      if ($urandom_range(9) == 0) o = $urandom;
      else o = ($urandom_range(0, 3) << table_model.shift) |
               $urandom_range(0, (1 << table_model.shift) - 1);
    end while (table_model.cost(k, c, l, o) > 1500);
    send(k, c, l, o);
  endtask

  task automatic run_phase(input bit f12, input logic [15:0] bnd, input logic [15:0] hnt,
                           input logic [4:0] sh, input int n, input bit idles);
    drain();
    write_cfg(REG_FAT12, {15'h0, f12});
    write_cfg(REG_BOUND, bnd);
    write_cfg(REG_HINT, hnt);
    write_cfg(REG_SHIFT, {11'h0, sh});
    idle_on = idles;
    repeat (n) random_item();
  endtask

  initial begin
    #1_000_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    table_model = new();
    idle_on = 1;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_READ;
    in_cluster <= 16'h0;
    in_link_value <= 16'h0;
    in_file_offset <= 32'h0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FAT12;
    cfg_wdata <= 16'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every kind, store edge, bad starts, broken and cyclic chains
    send(KIND_READ, 16'h0, 16'h0, 32'h0);
    send(KIND_READ, 16'hffff, 16'h0, 32'h0);
    send(KIND_WRITE, 16'd2, 16'hffff, 32'h0);
    send(KIND_WRITE, 16'd4095, 16'h1234, 32'h0);
    send(KIND_READ, 16'd4095, 16'h0, 32'h0);
    send(KIND_WRITE, 16'd4096, 16'h5555, 32'h0);
    send(KIND_FIND, 16'h0, 16'h0, 32'h0);
    send(KIND_FIND, 16'hffff, 16'h0, 32'h0);
    send(KIND_FREE, 16'h0, 16'h0, 32'h0);
    send(KIND_FREE, 16'hfff8, 16'h0, 32'h0);
    send(KIND_EXTEND, 16'd2, 16'h0, 32'h0);
    send(KIND_SEEK, 16'd2, 16'h0, 32'h0);
    send(KIND_SEEK, 16'd2, 16'h0, 32'h200);
    send(KIND_SEEK, 16'd5000, 16'h0, 32'h0);
    send(3'd6, 16'hffff, 16'hffff, 32'hffffffff);
    send(3'd7, 16'd2, 16'h0, 32'h0);
    send(KIND_WRITE, 16'd10, 16'd1, 32'h0);
    send(KIND_FREE, 16'd10, 16'h0, 32'h0);
    send(KIND_EXTEND, 16'd10, 16'h0, 32'h0);
    send(KIND_WRITE, 16'd20, 16'd21, 32'h0);
    send(KIND_WRITE, 16'd21, 16'd20, 32'h0);
    send(KIND_SEEK, 16'd20, 16'h0, 32'hffffffff);
    send(KIND_FREE, 16'd20, 16'h0, 32'h0);
    drain();
    write_cfg(REG_BOUND, 16'd3);
    send(KIND_FIND, 16'h0, 16'h0, 32'h0);
    send(KIND_EXTEND, 16'd2, 16'h0, 32'h0);

    run_phase(1'b1, 16'd200, 16'd2, 5'd9, 250, 1'b1);
    run_phase(1'b0, 16'd4095, 16'hffff, 5'd16, 200, 1'b0);
    run_phase(1'b1, 16'hffff, 16'd3000, 5'd12, 150, 1'b1);
    run_phase(1'b0, 16'd300, 16'd2, 5'd9, 300, 1'b1);
    run_phase(1'b1, 16'd3, 16'd2, 5'd16, 100, 1'b1);
    run_phase(1'b0, 16'd1000, 16'd500, 5'd13, 350, 1'b1);
    drain();
    repeat (20) @(posedge clk);
    if (table_model.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/fcce_pkg.sv
hw/rtl/fcce_byte_ram.sv
hw/rtl/fat_cluster_chain_engine.sv
bench/testbench.sv
